// ===== design/fsr_pkg.sv =====
// Package for the framed status receiver: payload limit, marker and
// character codes, parser phase type and prefix lookup.
// No dependencies.
package fsr_pkg;

  localparam int unsigned MaxPayload = 30;
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned PrefixLen  = 3;

  localparam logic [7:0] StartMark = 8'h3C;
  localparam logic [7:0] EndMark   = 8'h3E;
  localparam logic [7:0] CharQ     = 8'h51;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic [1:0] PlayMax = 2'd3;

  typedef logic [CntW-1:0] pcnt_t;

  typedef enum logic [1:0] {
    PhSkip,
    PhDigits,
    PhDone
  } num_phase_e;

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CharQ;
      2'd1:    c = CharP;
      default: c = CharA;
    endcase
    return c;
  endfunction

endpackage

// ===== design/fsr_if.sv =====
// Handshake interfaces for the framed status receiver: byte input channel
// and status result channel.
// Depends on nothing.
interface fsr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fsr_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] playing_count;
  logic       frame_closed;
  logic       status_report;

  modport source (output valid, output playing_count, output frame_closed,
                  output status_report, input ready);
  modport sink   (input valid, input playing_count, input frame_closed,
                  input status_report, output ready);
endinterface

// ===== design/framed_status_receiver.sv =====
// Framed status receiver: parses '<'...'>' frames and tracks QPA play reports.
// Depends on fsr_pkg and the fsr_byte_if / fsr_status_if interfaces.
//
// Usage:
//   rx_i carries one received byte per transaction (valid/ready).
//   status_o returns exactly one result per accepted byte: the playing
//   counter after that byte, whether the byte closed a frame, and whether
//   the closed frame was a QPA report.
//   Path: a byte accepted on rx_i is held in the input register, passes
//   through the frame/parser update into the result register, and its
//   result is offered on status_o from there.
//   Throughput: one byte per cycle while status_o does not stall, set by
//   the frame/parser update between the input and result registers.
//   Reset (rst_ni low, asynchronous) clears the frame state, the parser and
//   the playing counter and empties both register stages.
//   When status_o stalls, the result register holds, the input register
//   still fills once, and rx_i.ready then drops until the result is taken.
module framed_status_receiver
  import fsr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  fsr_byte_if.sink     rx_i,
  fsr_status_if.source status_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       res_vld_q, res_vld_d;
  logic       res_ready, adv, rx_take;

  logic       in_frame_q, in_frame_d;
  pcnt_t      cnt_q, cnt_d;
  logic [1:0] prefix_q, prefix_d;
  num_phase_e phase_q, phase_d;
  logic [7:0] value_q, value_d;
  logic [1:0] play_q, play_d;

  logic       closed, report;
  logic       is_digit, is_space, is_sign;

  logic [1:0] res_play_q;
  logic       res_closed_q, res_report_q;

  assign res_ready = !res_vld_q || status_o.ready;
  assign adv       = in_vld_q && res_ready;
  assign rx_i.ready = !in_vld_q || adv;
  assign rx_take   = rx_i.valid && rx_i.ready;

  assign in_vld_d  = rx_take ? 1'b1 : (adv ? 1'b0 : in_vld_q);
  assign res_vld_d = adv ? 1'b1 : (status_o.ready ? 1'b0 : res_vld_q);

  assign is_digit = (byte_q >= CharZero) && (byte_q <= CharNine);
  assign is_space = (byte_q == CharSpace) || ((byte_q >= CharTab) && (byte_q <= CharCr));
  assign is_sign  = (byte_q == CharPlus) || (byte_q == CharMinus);

  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    prefix_d   = prefix_q;
    phase_d    = phase_q;
    value_d    = value_q;
    play_d     = play_q;
    closed     = 1'b0;
    report     = 1'b0;
    if (in_frame_q) begin
      if (byte_q == EndMark) begin
        closed = 1'b1;
        if (prefix_q == 2'(PrefixLen)) begin
          report = 1'b1;
          if (value_q != 8'd0) begin
            if (play_q != PlayMax) play_d = play_q + 2'd1;
          end else if (play_q != 2'd0) begin
            play_d = play_q - 2'd1;
          end
        end
        in_frame_d = 1'b0;
        cnt_d      = '0;
        prefix_d   = 2'd0;
        phase_d    = PhSkip;
        value_d    = 8'd0;
      end else if (cnt_q < CntW'(MaxPayload)) begin
        if (cnt_q < CntW'(PrefixLen)) begin
          if ((prefix_q == cnt_q[1:0]) && (byte_q == prefix_char(cnt_q[1:0]))) begin
            prefix_d = prefix_q + 2'd1;
          end
        end else if (phase_q != PhDone) begin
          if (is_digit) begin
            value_d = (value_q << 3) + (value_q << 1) + {4'd0, byte_q[3:0]};
            phase_d = PhDigits;
          end else if ((phase_q == PhSkip) && is_space) begin
            phase_d = PhSkip;
          end else if ((phase_q == PhSkip) && is_sign) begin
            phase_d = PhDigits;
          end else begin
            phase_d = PhDone;
          end
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (byte_q == StartMark) begin
      in_frame_d = 1'b1;
      cnt_d      = '0;
      prefix_d   = 2'd0;
      phase_d    = PhSkip;
      value_d    = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      res_vld_q  <= 1'b0;
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      prefix_q   <= 2'd0;
      phase_q    <= PhSkip;
      value_q    <= 8'd0;
      play_q     <= 2'd0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      if (adv) begin
        in_frame_q <= in_frame_d;
        cnt_q      <= cnt_d;
        prefix_q   <= prefix_d;
        phase_q    <= phase_d;
        value_q    <= value_d;
        play_q     <= play_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      byte_q <= rx_i.rx_byte;
    end
    if (adv) begin
      res_play_q   <= play_d;
      res_closed_q <= closed;
      res_report_q <= report;
    end
  end

  assign status_o.valid         = res_vld_q;
  assign status_o.playing_count = res_play_q;
  assign status_o.frame_closed  = res_closed_q;
  assign status_o.status_report = res_report_q;

endmodule

// ===== design/fsr_checker.sv =====
// Port-level checker for the framed status receiver, bound to the top level.
// Depends on framed_status_receiver and its interface ports.
module fsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] playing_count_i,
  input logic       frame_closed_i,
  input logic       status_report_i
);

  logic       out_take;
  logic [1:0] last_cnt_q;

  assign out_take = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= 2'd0;
    end else if (out_take) begin
      last_cnt_q <= playing_count_i;
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  a_report_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_report_i |-> frame_closed_i)
    else $error("status report without frame close");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !status_report_i |-> playing_count_i == last_cnt_q)
    else $error("playing count moved without a report");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && status_report_i |->
      ({1'b0, playing_count_i} == {1'b0, last_cnt_q} + 3'd1) ||
      ({1'b0, playing_count_i} + 3'd1 == {1'b0, last_cnt_q}) ||
      (playing_count_i == last_cnt_q))
    else $error("playing count stepped by more than one");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(playing_count_i) &&
      $stable(frame_closed_i) && $stable(status_report_i))
    else $error("stalled result changed");

endmodule

bind framed_status_receiver fsr_checker u_fsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (status_o.valid),
  .out_ready_i     (status_o.ready),
  .playing_count_i (status_o.playing_count),
  .frame_closed_i  (status_o.frame_closed),
  .status_report_i (status_o.status_report)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for framed_status_receiver: directed table, then random frames.
// Checks every status transaction against a cycle-free predictor, or a fixed expected status for typed directed rows.
// Depends on fsr_pkg, fsr_byte_if, fsr_status_if and the design top.
module tb;
  import fsr_pkg::*;

  typedef struct packed {
    logic [1:0] playing_count;
    logic       frame_closed;
    logic       status_report;
  } status_t;

  typedef struct {
    logic [7:0] rx_byte;
    bit         typed;
    status_t    exp;
  } dir_row_t;

  localparam status_t Quiet      = '{2'd0, 1'b0, 1'b0};
  localparam status_t FirstPlay  = '{2'd1, 1'b1, 1'b1};
  localparam status_t EmptyFrame = '{2'd1, 1'b1, 1'b0};
  localparam status_t ZeroReport = '{2'd0, 1'b1, 1'b1};
  localparam int      RandBytes  = 1200;
  localparam int      LongHold   = 80;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fsr_byte_if   rx ();
  fsr_status_if st ();

  framed_status_receiver dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .rx_i    (rx),
    .status_o(st)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // predictor state
  logic                 fr_open   = 1'b0;
  pcnt_t                fr_len    = '0;
  logic [1:0]           fr_prefix = '0;
  num_phase_e           fr_phase  = PhSkip;
  logic [7:0]           fr_value  = '0;
  logic [1:0]           play_cnt  = '0;
  logic [7:0]           qpa_chars [3] = '{CharQ, CharP, CharA};

  status_t    status_q [$];
  logic [7:0] stim_q   [$];
  int         err_count    = 0;
  int         bytes_sent   = 0;
  int         useful_bytes = 0;
  int         tx_calm      = 0;

  dir_row_t dir_rows [25] = '{
    '{8'h00,          1'b1, Quiet},
    '{8'hFF,          1'b1, Quiet},
    '{EndMark,        1'b1, Quiet},
    '{StartMark,      1'b1, Quiet},
    '{CharQ,          1'b0, Quiet},
    '{CharP,          1'b0, Quiet},
    '{CharA,          1'b0, Quiet},
    '{CharZero + 8'd7, 1'b0, Quiet},
    '{EndMark,        1'b1, FirstPlay},
    '{StartMark,      1'b0, Quiet},
    '{EndMark,        1'b1, EmptyFrame},
    '{StartMark,      1'b0, Quiet},
    '{CharQ,          1'b0, Quiet},
    '{CharP,          1'b0, Quiet},
    '{CharA,          1'b0, Quiet},
    '{EndMark,        1'b1, ZeroReport},
    '{StartMark,      1'b0, Quiet},
    '{CharQ,          1'b0, Quiet},
    '{CharP,          1'b0, Quiet},
    '{CharA,          1'b0, Quiet},
    '{CharTab,        1'b0, Quiet},
    '{CharMinus,      1'b0, Quiet},
    '{CharNine,       1'b0, Quiet},
    '{8'h00,          1'b0, Quiet},
    '{EndMark,        1'b0, Quiet}
  };

  function automatic void clear_frame_state();
    fr_len    = '0;
    fr_prefix = '0;
    fr_phase  = PhSkip;
    fr_value  = '0;
  endfunction

  function automatic void parse_number(input logic [7:0] b);
    if (fr_phase == PhDone) return;
    if (b >= CharZero && b <= CharNine) begin
      fr_value = fr_value * 8'd10 + (b - CharZero);
      fr_phase = PhDigits;
    end else if (fr_phase == PhSkip && (b == CharSpace || (b >= CharTab && b <= CharCr))) begin
    end else if (fr_phase == PhSkip && (b == CharPlus || b == CharMinus)) begin
      fr_phase = PhDigits;
    end else begin
      fr_phase = PhDone;
    end
  endfunction

  function automatic status_t advance_receiver(input logic [7:0] b);
    logic closed;
    logic report;
    closed = 1'b0;
    report = 1'b0;
    if (fr_open) begin
      if (b == EndMark) begin
        closed = 1'b1;
        if (fr_prefix == PrefixLen) begin
          report = 1'b1;
          if (fr_value != 0) begin
            if (play_cnt != PlayMax) play_cnt = play_cnt + 2'd1;
          end else if (play_cnt != 0) begin
            play_cnt = play_cnt - 2'd1;
          end
        end
        fr_open = 1'b0;
        clear_frame_state();
      end else if (fr_len < MaxPayload) begin
        if (fr_len < PrefixLen) begin
          if (fr_prefix == fr_len[1:0] && b == qpa_chars[fr_len[1:0]])
            fr_prefix = fr_prefix + 2'd1;
        end else begin
          parse_number(b);
        end
        fr_len = fr_len + pcnt_t'(1);
      end
    end else if (b == StartMark) begin
      fr_open = 1'b1;
      clear_frame_state();
    end
    return '{play_cnt, closed, report};
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_status
    status_t want;
    if (rst_n && st.valid && st.ready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = status_q.pop_front();
        if (st.playing_count !== want.playing_count)
          report_mismatch("playing_count", int'(st.playing_count),
                          int'(want.playing_count));
        if (st.frame_closed !== want.frame_closed)
          report_mismatch("frame_closed", int'(st.frame_closed),
                          int'(want.frame_closed));
        if (st.status_report !== want.status_report)
          report_mismatch("status_report", int'(st.status_report),
                          int'(want.status_report));
      end
    end
  end

  initial begin : drive_status_ready
    int hold_left;
    int calm_left;
    int r;
    bit long_done;
    hold_left = 0;
    calm_left = 0;
    long_done = 1'b0;
    st.ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_done && bytes_sent >= 200) begin
        long_done = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        st.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        st.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) calm_left = $urandom_range(20, 60);
        if (r < 70) begin
          st.ready <= 1'b1;
        end else begin
          if (r >= 95) hold_left = $urandom_range(5, 25);
          st.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) tx_calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == EndMark);
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] space_byte();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CharSpace : CharTab + 8'(r);
  endfunction

  task automatic push_frame_byte(input logic [7:0] b);
    stim_q.push_back(b);
    useful_bytes++;
  endtask

  task automatic add_qpa_frame();
    int n;
    int r;
    push_frame_byte(StartMark);
    foreach (qpa_chars[i]) push_frame_byte(qpa_chars[i]);
    repeat ($urandom_range(0, 2)) push_frame_byte(space_byte());
    r = $urandom_range(0, 9);
    if (r < 4) push_frame_byte($urandom_range(0, 1) ? CharPlus : CharMinus);
    if (r == 3) push_frame_byte($urandom_range(0, 1) ? CharPlus : CharMinus);
    n = $urandom_range(0, 4);
    r = $urandom_range(0, 5);
    if (r < 2) begin
      repeat (n) push_frame_byte(CharZero);
    end else if (r == 2) begin
      push_frame_byte(CharZero + 8'd2);
      push_frame_byte(CharZero + 8'd5);
      push_frame_byte(CharZero + 8'd6);
    end else begin
      repeat (n + 1) push_frame_byte(digit_byte());
    end
    r = $urandom_range(0, 4);
    if (r == 0) push_frame_byte(8'h00);
    if (r < 2) repeat ($urandom_range(0, 3)) push_frame_byte(payload_byte());
    push_frame_byte(EndMark);
  endtask

  task automatic add_random_frame();
    int k;
    k = $urandom_range(0, 19);
    if (k < 2) begin
      repeat ($urandom_range(1, 4)) stim_q.push_back(8'($urandom_range(0, 255)));
    end else if (k < 4) begin
      push_frame_byte(StartMark);
      repeat ($urandom_range(0, 6)) push_frame_byte(payload_byte());
      push_frame_byte(EndMark);
    end else if (k == 4) begin
      push_frame_byte(StartMark);
      foreach (qpa_chars[i]) push_frame_byte(qpa_chars[i]);
      repeat ($urandom_range(24, 40))
        push_frame_byte($urandom_range(0, 3) == 0 ? payload_byte() : digit_byte());
      push_frame_byte(EndMark);
    end else if (k < 7) begin
      push_frame_byte(StartMark);
      for (int i = 0; i < $urandom_range(0, 4); i++)
        push_frame_byte($urandom_range(0, 2) == 0 ? payload_byte() : qpa_chars[i % 3]);
      push_frame_byte(EndMark);
    end else begin
      add_qpa_frame();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed, input status_t fixed_exp);
    int      gap;
    status_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    pred = advance_receiver(b);
    status_q.push_back(typed ? fixed_exp : pred);
    bytes_sent++;
    @(negedge clk);
  endtask

  initial begin : drive_bytes
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].rx_byte, dir_rows[i].typed, dir_rows[i].exp);
    while (useful_bytes < RandBytes) add_random_frame();
    foreach (stim_q[i]) send_byte(stim_q[i], 1'b0, Quiet);
    rx.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
